// File: rtl/core/cip_pkg.sv
// Shared types and constants for the control IN data-stage packetizer.
// Holds the input and result item structs and the result queue sizing.
// No dependencies.
package cip_pkg;

    // Command codes carried in the cmd field.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Default maximum packet size in bytes.
    localparam int PACKET_BYTES_DEF = 8;

    // Descriptor type byte sent after the length in string mode.
    localparam logic [7:0] STRING_DESC_TYPE = 8'd3;

    // Most results one input item can cause, and the result queue depth.
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    // One input item.
    typedef struct packed {
        logic        cmd;
        logic [15:0] requested_length;
        logic [15:0] source_length;
        logic        string_mode;
        logic [7:0]  data_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       packet_end;
        logic       transfer_end;
    } t_out_item;

    // Builds one result item.
    function automatic t_out_item make_result(logic [7:0] b, logic valid, logic pend,
                                              logic tend);
        t_out_item r;
        r.out_byte     = b;
        r.byte_valid   = valid;
        r.packet_end   = pend;
        r.transfer_end = tend;
        return r;
    endfunction

endpackage

// File: rtl/core/control_in_packetizer.sv
// Top level of the control IN data-stage packetizer.
// Depends on cip_pkg for the item structs, command codes and queue sizing.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Each accepted item updates the transfer state in the cycle it is taken and
// writes its zero to three results into a four-entry result queue.
// The result port moves one byte per cycle while i_out_ready is high, so plain data
// runs at one item per cycle unless stalled; string items give at least two results.
// The input side is ready while at most one result waits in the queue.
// Reset (synchronous, active low) empties the queue and returns to idle.
module control_in_packetizer
    import cip_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Fill counter wide enough for PACKET_BYTES plus one pair.
    localparam int FW  = $clog2(PACKET_BYTES + 3);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0]  PKT_LEN     = FW'(PACKET_BYTES);
    localparam logic [QCW-1:0] READY_LIMIT = QCW'(QUEUE_DEPTH - MAX_RESULTS);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DATA  = 3'b010,
        PH_DRAIN = 3'b100
    } t_phase;

    // Transfer state.
    t_phase        r_phase, n_phase;
    logic [15:0]   r_remaining, n_remaining;
    logic [15:0]   r_source_left, n_source_left;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_explicit_stop, n_explicit_stop;
    logic          r_mode_string, n_mode_string;

    // Result queue.
    t_out_item      r_queue [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count, n_count;

    t_out_item  push_item [MAX_RESULTS];
    logic [1:0] push_cnt;
    logic       in_fire, out_fire;

    // Start decode helpers; the string total reaches 2 + 2*65535.
    logic [17:0]   str_total;
    logic [15:0]   start_rem;
    logic [15:0]   str_rem;
    logic [15:0]   src_dec;
    logic [15:0]   step_rem;
    logic [FW-1:0] step_fill;
    logic          step_full, step_last, step_pend, step_zlp;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_in_ready  = r_count <= READY_LIMIT;
    assign o_out_valid = r_count != '0;
    assign o_out_item  = r_queue[r_rd_ptr];

    // Arithmetic shared by the start and data paths.
    always_comb begin
        str_total = {1'b0, i_in_item.source_length, 1'b0} + 18'd2;
        if (i_in_item.string_mode) begin
            start_rem = ({2'b0, i_in_item.requested_length} > str_total)
                        ? str_total[15:0] : i_in_item.requested_length;
        end else begin
            start_rem = (i_in_item.source_length >= i_in_item.requested_length)
                        ? i_in_item.requested_length : i_in_item.source_length;
        end
        str_rem = (start_rem > 16'd2) ? start_rem - 16'd2 : '0;
        src_dec = (r_source_left != '0) ? r_source_left - 16'd1 : '0;
        if (r_mode_string) begin
            step_fill = r_fill + FW'(2);
            step_rem  = (r_remaining > 16'd2) ? r_remaining - 16'd2 : '0;
            step_full = (step_fill + FW'(2)) > PKT_LEN;
            step_last = step_rem == '0;
            step_zlp  = step_last && r_explicit_stop && (step_fill == PKT_LEN);
        end else begin
            step_fill = r_fill + FW'(1);
            step_rem  = (r_remaining != '0) ? r_remaining - 16'd1 : '0;
            step_full = step_fill >= PKT_LEN;
            step_last = step_rem == '0;
            step_zlp  = step_last && r_explicit_stop && step_full;
        end
        step_pend = step_full || step_last;
    end

    // Next transfer state and the results one item causes.
    always_comb begin
        n_phase         = r_phase;
        n_remaining     = r_remaining;
        n_source_left   = r_source_left;
        n_fill          = r_fill;
        n_explicit_stop = r_explicit_stop;
        n_mode_string   = r_mode_string;
        push_cnt        = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            push_item[k] = make_result(8'd0, 1'b0, 1'b1, 1'b1);
        end
        if (in_fire) begin
            if (i_in_item.cmd == CMD_START) begin
                n_mode_string = i_in_item.string_mode;
                n_source_left = i_in_item.source_length;
                n_fill        = '0;
                if (!i_in_item.string_mode) begin
                    n_explicit_stop = i_in_item.source_length < i_in_item.requested_length;
                    if (start_rem == '0) begin
                        // Nothing to send: a single zero-length packet.
                        push_cnt    = 2'd1;
                        n_phase     = (i_in_item.source_length != '0) ? PH_DRAIN : PH_IDLE;
                        n_remaining = '0;
                    end else begin
                        n_remaining = start_rem;
                        n_phase     = PH_DATA;
                    end
                end else begin
                    n_explicit_stop = {2'b0, i_in_item.requested_length} > str_total;
                    push_cnt        = 2'd2;
                    push_item[0]    = make_result(str_total[7:0], 1'b1, 1'b0, 1'b0);
                    n_remaining     = str_rem;
                    if (str_rem == '0) begin
                        // The header alone is the whole transfer.
                        push_item[1] = make_result(STRING_DESC_TYPE, 1'b1, 1'b1, 1'b1);
                        n_phase      = (i_in_item.source_length != '0) ? PH_DRAIN : PH_IDLE;
                        n_fill       = '0;
                    end else begin
                        push_item[1] = make_result(STRING_DESC_TYPE, 1'b1, 1'b0, 1'b0);
                        n_fill       = FW'(2);
                        n_phase      = PH_DATA;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_DRAIN: begin
                        // Surplus source bytes are taken and dropped.
                        n_source_left = src_dec;
                        if (src_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        n_source_left = src_dec;
                        n_remaining   = step_rem;
                        n_fill        = step_pend ? '0 : step_fill;
                        if (r_mode_string) begin
                            push_cnt     = step_zlp ? 2'd3 : 2'd2;
                            push_item[0] = make_result(i_in_item.data_byte, 1'b1, 1'b0, 1'b0);
                            push_item[1] = make_result(8'd0, 1'b1, step_pend,
                                                       step_last && !step_zlp);
                        end else begin
                            push_cnt     = step_zlp ? 2'd2 : 2'd1;
                            push_item[0] = make_result(i_in_item.data_byte, 1'b1, step_pend,
                                                       step_last && !step_zlp);
                        end
                        if (step_last) begin
                            n_phase     = (src_dec != '0) ? PH_DRAIN : PH_IDLE;
                            n_remaining = '0;
                            n_fill      = '0;
                        end
                    end
                    PH_IDLE: begin
                        // A data item with no transfer open is ignored.
                    end
                    default: begin
                    end
                endcase
            end
        end
        n_count = r_count + QCW'(push_cnt) - QCW'(out_fire);
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_remaining     <= '0;
            r_source_left   <= '0;
            r_fill          <= '0;
            r_explicit_stop <= 1'b0;
            r_mode_string   <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            r_phase         <= n_phase;
            r_remaining     <= n_remaining;
            r_source_left   <= n_source_left;
            r_fill          <= n_fill;
            r_explicit_stop <= n_explicit_stop;
            r_mode_string   <= n_mode_string;
            r_wr_ptr        <= r_wr_ptr + QAW'(push_cnt);
            r_rd_ptr        <= r_rd_ptr + QAW'(out_fire);
            r_count         <= n_count;
        end
    end

    // Result queue storage; results enter in order at the write pointer.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push_cnt) begin
                r_queue[r_wr_ptr + QAW'(k)] <= push_item[k];
            end
        end
    end

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Outside the data phase no bytes are owed to the host.
    a_rem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DATA) |-> (r_remaining == '0))
        else $error("remaining count left over outside data phase");

    // In the data phase at least one byte is still owed.
    a_rem_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != '0))
        else $error("data phase with nothing left to send");

    // Draining only happens while source bytes remain.
    a_drain_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DRAIN) |-> (r_source_left != '0))
        else $error("drain phase with empty source");

    // A full packet always closes, so the fill stays below the packet size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < PKT_LEN)
        else $error("packet fill reached packet size");

endmodule

// File: sim/tb_control_in_packetizer.sv
// Self-checking testbench for control_in_packetizer: directed and random IN data stages.
// A built-in predictor computes the expected result items and compares them with the block.
// Depends on cip_pkg and the control_in_packetizer RTL.
module tb_control_in_packetizer;
    timeunit 1ns;
    timeprecision 1ps;

    import cip_pkg::*;

    // Transfer progress as the predictor tracks it.
    typedef enum logic [2:0] {
        XS_IDLE  = 3'b001,
        XS_SEND  = 3'b010,
        XS_FLUSH = 3'b100
    } t_xfer_state;

    // One pending input item; hold_for_empty makes the sender wait for all results first.
    typedef struct {
        t_in_item item;
        bit       hold_for_empty;
    } t_feed_entry;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_feed_entry feed_q[$];
    t_out_item   expected_q[$];
    int          fail_count = 0;
    int          in_gap = 0;
    int          out_stall = 0;
    int          idle_timer = 0;
    bit          idle_on = 1'b0;
    bit          quiet = 1'b0;
    bit          results_clear = 1'b1;

    // Predictor state.
    t_xfer_state xs = XS_IDLE;
    int          bytes_left = 0;
    int          src_count = 0;
    int          pkt_fill = 0;
    bit          zlp_owed = 1'b0;
    bit          str_xfer = 1'b0;

    control_in_packetizer #(
        .PACKET_BYTES(PACKET_BYTES_DEF)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Clock generation.
    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR: %s", what);
        end
    endfunction

    function automatic void push_result(logic [7:0] b, logic v, logic pe, logic te);
        t_out_item r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.packet_end   = pe;
        r.transfer_end = te;
        expected_q.push_back(r);
    endfunction

    // Closing a transfer leaves any unsent source bytes to be swallowed.
    function automatic void end_transfer();
        xs         = (src_count != 0) ? XS_FLUSH : XS_IDLE;
        bytes_left = 0;
        pkt_fill   = 0;
    endfunction

    // Advances the predicted packetizer by one accepted item and queues its results.
    function automatic void packetize_step(t_in_item it);
        int cnt;
        int total;
        bit full;
        bit last;
        bit pend;
        bit zlp;
        if (it.cmd == CMD_START) begin
            str_xfer  = it.string_mode;
            src_count = int'(it.source_length);
            pkt_fill  = 0;
            if (!it.string_mode) begin
                if (it.source_length >= it.requested_length) begin
                    cnt      = int'(it.requested_length);
                    zlp_owed = 1'b0;
                end else begin
                    cnt      = int'(it.source_length);
                    zlp_owed = 1'b1;
                end
                if (cnt == 0) begin
                    push_result(8'h00, 1'b0, 1'b1, 1'b1);
                    end_transfer();
                end else begin
                    bytes_left = cnt;
                    xs         = XS_SEND;
                end
            end else begin
                // Header: descriptor length byte, then the string type.
                total = 2 + 2 * int'(it.source_length);
                if (int'(it.requested_length) > total) begin
                    zlp_owed = 1'b1;
                    cnt      = total;
                end else begin
                    zlp_owed = 1'b0;
                    cnt      = int'(it.requested_length);
                end
                push_result(total[7:0], 1'b1, 1'b0, 1'b0);
                cnt        = (cnt > 2) ? cnt - 2 : 0;
                pkt_fill   = 2;
                bytes_left = cnt;
                if (cnt == 0) begin
                    push_result(STRING_DESC_TYPE, 1'b1, 1'b1, 1'b1);
                    end_transfer();
                end else begin
                    push_result(STRING_DESC_TYPE, 1'b1, 1'b0, 1'b0);
                    xs = XS_SEND;
                end
            end
        end else if (xs == XS_FLUSH) begin
            if (src_count > 0) src_count--;
            if (src_count == 0) xs = XS_IDLE;
        end else if (xs == XS_SEND) begin
            if (src_count > 0) src_count--;
            if (!str_xfer) begin
                pkt_fill++;
                if (bytes_left > 0) bytes_left--;
                full = pkt_fill >= PACKET_BYTES_DEF;
                last = bytes_left == 0;
                pend = full || last;
                zlp  = last && zlp_owed && full;
                push_result(it.data_byte, 1'b1, pend, last && !zlp);
            end else begin
                // Each character becomes the character and a zero byte; pairs never split.
                pkt_fill  += 2;
                bytes_left = (bytes_left > 2) ? bytes_left - 2 : 0;
                full = pkt_fill + 2 > PACKET_BYTES_DEF;
                last = bytes_left == 0;
                pend = full || last;
                zlp  = last && zlp_owed && (pkt_fill == PACKET_BYTES_DEF);
                push_result(it.data_byte, 1'b1, 1'b0, 1'b0);
                push_result(8'h00, 1'b1, pend, last && !zlp);
            end
            if (zlp) push_result(8'h00, 1'b0, 1'b1, 1'b1);
            if (pend) pkt_fill = 0;
            if (last) end_transfer();
        end
    endfunction

    function automatic logic [15:0] sat16(int v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void queue_item(logic cmd, logic [15:0] rq, logic [15:0] sl, logic sm,
                                       logic [7:0] db, bit hold);
        t_feed_entry e;
        e.item.cmd              = cmd;
        e.item.requested_length = rq;
        e.item.source_length    = sl;
        e.item.string_mode      = sm;
        e.item.data_byte        = db;
        e.hold_for_empty        = hold;
        feed_q.push_back(e);
    endfunction

    // A start item followed by source items with random content; unused fields are noise.
    function automatic void queue_transfer(logic sm, logic [15:0] rq, logic [15:0] sl,
                                           int nbytes, bit hold);
        queue_item(CMD_START, rq, sl, sm, 8'($urandom_range(0, 255)), hold);
        for (int k = 0; k < nbytes; k++) begin
            queue_item(CMD_DATA, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
        end
    endfunction

    // Requested lengths cluster around the source size to hit exact, short and long cases.
    function automatic logic [15:0] pick_request(logic sm, int sl);
        int r;
        int full_len;
        r        = $urandom_range(0, 99);
        full_len = sm ? 2 + 2 * sl : sl;
        if (r < 30) return 16'($urandom_range(0, 48));
        if (r < 55) return sat16(full_len);
        if (r < 75) return sat16(full_len + $urandom_range(1, 20));
        if (r < 88) return (full_len > 0) ? sat16($urandom_range(0, full_len - 1)) : 16'h0000;
        if (r < 94) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Stimulus, reset and end of run.
    initial begin : run_ctl
        int counted;
        int sl;
        int nbytes;
        int r;
        logic sm;

        // Directed part.
        queue_item(CMD_DATA, 16'h0000, 16'h0000, 1'b0, 8'hFF, 1'b0);   // byte while idle
        queue_transfer(1'b0, 16'd0, 16'd0, 0, 1'b0);                   // empty plain transfer
        queue_transfer(1'b0, 16'd0, 16'd2, 2, 1'b0);                   // surplus bytes drained
        queue_transfer(1'b1, 16'd0, 16'd1, 1, 1'b0);                   // short string request
        queue_transfer(1'b1, 16'd1, 16'd0, 0, 1'b0);
        // Host asks for more than a full packet of source: zero-length packet follows.
        queue_item(CMD_START, 16'd20, 16'd8, 1'b0, 8'h00, 1'b0);
        for (int k = 0; k < 8; k++) begin
            queue_item(CMD_DATA, 16'hFFFF, 16'hFFFF, 1'b1, (k % 2) ? 8'hFF : 8'h00, 1'b0);
        end
        queue_transfer(1'b1, 16'd255, 16'd3, 3, 1'b0);                 // full string packet
        queue_transfer(1'b0, 16'hFFFF, 16'hFFFF, 1, 1'b0);             // abandoned by next start
        queue_transfer(1'b1, 16'd5, 16'd1, 1, 1'b0);                   // odd request in string mode

        // Random transfers, mostly well formed.
        counted = 0;
        while (counted < 500) begin
            if ($urandom_range(0, 99) < 4) begin
                queue_item(CMD_DATA, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 1'b0);
            end
            sm = 1'($urandom_range(0, 1));
            r  = $urandom_range(0, 99);
            if (r < 75) sl = $urandom_range(0, 20);
            else if (r < 85) sl = $urandom_range(21, 40);
            else if (r < 95) sl = $urandom_range(41, 65535);
            else sl = 65535;
            r = $urandom_range(0, 99);
            if (sl <= 40) begin
                if (r < 80) nbytes = sl;
                else if (r < 92) nbytes = $urandom_range(0, sl);
                else nbytes = sl + $urandom_range(1, 3);
            end else begin
                nbytes = $urandom_range(0, 20);
            end
            queue_transfer(sm, pick_request(sm, sl), sl[15:0], nbytes,
                           counted == 0 || $urandom_range(0, 99) < 3);
            counted += 1 + ((nbytes < sl) ? nbytes : sl);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_valid) @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Idling comes and goes in stretches.
    always @(posedge clk) begin
        if (idle_timer == 0) begin
            idle_timer <= $urandom_range(50, 300);
            idle_on    <= ($urandom_range(0, 3) != 0);
        end else begin
            idle_timer <= idle_timer - 1;
        end
    end

    // Input driver: presents queued items, with random gaps between them.
    always @(posedge clk) begin : feed_driver
        logic     nv;
        t_in_item ni;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nv = in_valid;
            ni = in_item;
            if (in_valid && in_ready) begin
                void'(feed_q.pop_front());
                nv = 1'b0;
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (feed_q.size() != 0 &&
                             !(feed_q[0].hold_for_empty && !(results_clear && !in_valid))) begin
                    if (!quiet && idle_on && $urandom_range(0, 99) < 20) begin
                        in_gap = $urandom_range(1, 12);
                    end else begin
                        nv = 1'b1;
                        ni = feed_q[0].item;
                    end
                end
            end
            in_valid <= nv;
            in_item  <= ni;
            quiet    <= (feed_q.size() < 40);
        end
    end

    // Monitor: predicts on each accepted input item and checks each accepted result.
    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (!rst_n) begin
            out_ready     <= 1'b0;
            results_clear <= 1'b1;
        end else begin
            if (in_valid && in_ready) begin
                packetize_step(in_item);
            end
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    note_failure($sformatf("unexpected result byte=%02h valid=%b pend=%b tend=%b",
                                           out_item.out_byte, out_item.byte_valid,
                                           out_item.packet_end, out_item.transfer_end));
                end else begin
                    want = expected_q.pop_front();
                    if (out_item.out_byte !== want.out_byte ||
                        out_item.byte_valid !== want.byte_valid ||
                        out_item.packet_end !== want.packet_end ||
                        out_item.transfer_end !== want.transfer_end) begin
                        note_failure($sformatf(
                            "mismatch: exp %02h/%b/%b/%b, got %02h/%b/%b/%b",
                            want.out_byte, want.byte_valid, want.packet_end,
                            want.transfer_end, out_item.out_byte, out_item.byte_valid,
                            out_item.packet_end, out_item.transfer_end));
                    end
                end
            end
            results_clear <= (expected_q.size() == 0);

            // Receiver stalls in random bursts.
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else if (!quiet && idle_on && $urandom_range(0, 99) < 15) begin
                out_stall = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

endmodule
